// ----- hdl/two_circle_intersection_top_macros.svh -----
// Assertion helpers shared by the two-circle intersection RTL.
// Defining NO_ASSERTIONS removes every check.
`ifndef TWO_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`define TWO_CIRCLE_INTERSECTION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TCI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("two_circle_intersection: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("two_circle_intersection: next-cycle check failed");

`else

`define TCI_ASSERT_IMP(label, ante, cons)
`define TCI_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hdl/tci_pkg.sv -----
package tci_pkg;

    // Width of every coordinate field of the request and the result.
    localparam int COORD_W = 24;

    // Width of the multiplier digit handled by one multiplier cell.
    localparam int DIGIT_W = 8;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAME  = 2'd1;
    localparam logic [1:0] ST_APART = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One request: two landmarks, map and observed positions.
    typedef struct packed {
        t_coord first_map_x;
        t_coord first_map_y;
        t_coord first_seen_x;
        t_coord first_seen_y;
        t_coord second_map_x;
        t_coord second_map_y;
        t_coord second_seen_x;
        t_coord second_seen_y;
    } t_req;

    // One result: both intersection points and a status.
    typedef struct packed {
        t_coord     point_one_x;
        t_coord     point_one_y;
        t_coord     point_two_x;
        t_coord     point_two_y;
        logic [1:0] status;
    } t_res;

    // Number of cells of a multiplier with a bw-bit multiplier operand.
    function automatic int mul_lat(input int bw);
        return (bw + DIGIT_W - 1) / DIGIT_W;
    endfunction

endpackage

// ----- hdl/tci_delay.sv -----
module tci_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    // Shift line of N registers.
    logic [W-1:0] r_line [0:N-1];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < N; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_q = r_line[N-1];

endmodule

// ----- hdl/tci_mul.sv -----
module tci_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);
    import tci_pkg::*;

    localparam int NC = (BW + DIGIT_W - 1) / DIGIT_W;
    localparam int BP = NC * DIGIT_W;
    localparam int PW = AW + BW;

    logic signed [AW-1:0] r_a   [0:NC-1];
    logic signed [BP-1:0] r_b   [0:NC-1];
    logic signed [PW-1:0] r_acc [0:NC-1];

    // Each cell adds one digit's partial product and hands the rest on.
    for (genvar i = 0; i < NC; i++) begin : g_cell
        logic signed [AW-1:0]        cur_a;
        logic signed [BP-1:0]        cur_b;
        logic signed [PW-1:0]        cur_acc;
        logic signed [DIGIT_W:0]     dig;
        logic signed [AW+DIGIT_W:0]  part;
        logic signed [PW-1:0]        n_acc;

        if (i == 0) begin : g_first
            assign cur_a   = i_a;
            assign cur_b   = BP'(i_b);
            assign cur_acc = '0;
        end else begin : g_next
            assign cur_a   = r_a[i-1];
            assign cur_b   = r_b[i-1];
            assign cur_acc = r_acc[i-1];
        end

        // The top digit carries the sign of the multiplier operand.
        if (i == NC - 1) begin : g_top
            assign dig = {cur_b[BP-1], cur_b[BP-1 -: DIGIT_W]};
        end else begin : g_low
            assign dig = {1'b0, cur_b[DIGIT_W*i +: DIGIT_W]};
        end

        assign part  = cur_a * dig;
        assign n_acc = cur_acc + (PW'(part) <<< (DIGIT_W * i));

        always_ff @(posedge i_clk) begin
            r_a[i]   <= cur_a;
            r_b[i]   <= cur_b;
            r_acc[i] <= n_acc;
        end
    end

    assign o_p = r_acc[NC-1];

endmodule

// ----- hdl/tci_sqrt.sv -----
module tci_sqrt #(
    parameter int RB = 16
) (
    input  logic          i_clk,
    input  logic [2*RB-1:0] i_rad,
    output logic [RB-1:0] o_root
);
    logic [2*RB-1:0] r_rad  [0:RB-1];
    logic [RB+1:0]   r_rem  [0:RB-1];
    logic [RB-1:0]   r_root [0:RB-1];

    // Each cell settles one root bit, restoring form.
    for (genvar i = 0; i < RB; i++) begin : g_cell
        logic [2*RB-1:0] cur_rad;
        logic [RB+1:0]   cur_rem;
        logic [RB-1:0]   cur_root;
        logic [RB+1:0]   rem_sh;
        logic [RB+1:0]   trial;
        logic            ge;

        if (i == 0) begin : g_first
            assign cur_rad  = i_rad;
            assign cur_rem  = '0;
            assign cur_root = '0;
        end else begin : g_next
            assign cur_rad  = r_rad[i-1];
            assign cur_rem  = r_rem[i-1];
            assign cur_root = r_root[i-1];
        end

        assign rem_sh = {cur_rem[RB-1:0], cur_rad[2*RB-1 -: 2]};
        assign trial  = {cur_root, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            r_rad[i]  <= {cur_rad[2*RB-3:0], 2'b00};
            r_rem[i]  <= ge ? (rem_sh - trial) : rem_sh;
            r_root[i] <= {cur_root[RB-2:0], ge};
        end
    end

    assign o_root = r_root[RB-1];

endmodule

// ----- hdl/tci_div.sv -----
module tci_div #(
    parameter int DW = 16,
    parameter int QW = 8
) (
    input  logic             i_clk,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quo
);
    localparam int NW = DW + QW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];

    // Each cell settles one quotient bit, from the top down.
    for (genvar i = 0; i < QW; i++) begin : g_cell
        logic [NW-1:0] cur_rem;
        logic [DW-1:0] cur_den;
        logic [QW-1:0] cur_quo;
        logic [NW-1:0] sh;
        logic          ge;

        if (i == 0) begin : g_first
            assign cur_rem = i_num;
            assign cur_den = i_den;
            assign cur_quo = '0;
        end else begin : g_next
            assign cur_rem = r_rem[i-1];
            assign cur_den = r_den[i-1];
            assign cur_quo = r_quo[i-1];
        end

        assign sh = NW'(cur_den) << (QW - 1 - i);
        assign ge = (cur_rem >= sh);

        always_ff @(posedge i_clk) begin
            r_rem[i] <= ge ? (cur_rem - sh) : cur_rem;
            r_den[i] <= cur_den;
            r_quo[i] <= {cur_quo[QW-2:0], ge};
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ----- hdl/two_circle_intersection_top.sv -----
// Two-circle intersection: a position fix from two landmarks.
// Request channel: i_req holds both landmarks' map and observed positions and is
// taken at a clock edge where start is high and busy is low. busy is always low,
// so a new request may be issued in every cycle.
// Result channel: o_res holds both intersection points and a status; o_valid is
// high for exactly one cycle per request and the receiver must take it then.
// With the default 24-bit coordinates the result passes through a chain of cells:
// the 51-cell square root, the 24-cell dividers, the multiplier cells (one per
// 8-bit digit) and the adder stages.
// Throughput: one request per cycle; every cell works on a different request.
// Results leave in request order.
// Reset clears only the valid pipeline; no stale result appears after reset.
// The receiver cannot stall, so there is no back-pressure anywhere.
// Status: valid, coincident centers, or circles that do not meet; points
// are zero on either error.
`include "two_circle_intersection_top_macros.svh"
module two_circle_intersection_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tci_pkg::t_req i_req,
    output logic          o_valid,
    output tci_pkg::t_res o_res
);
    import tci_pkg::*;

    localparam int C    = COORD_W;
    localparam int E    = C + 1;
    localparam int R2   = 2 * E;
    localparam int AK   = R2 + 3;
    localparam int KW   = 2 * AK;
    localparam int RB   = R2 + 1;
    localparam int PNW  = R2 + 1 + E;
    localparam int TXW  = RB + 1 + E;
    localparam int BSW  = R2 + E + 2;
    localparam int NW   = R2 + E + 5;
    localparam int OW   = R2 + C + 1;
    localparam int TW   = R2 + 1;
    localparam int DV   = TW + C;
    localparam int LK   = mul_lat(AK);
    localparam int LN   = mul_lat(E);
    localparam int T_K  = 4 + LK + 1;
    localparam int T_RT = T_K + RB;
    localparam int T_TX = T_RT + LN;
    localparam int T_DP = T_TX + 2;
    localparam int T_Q  = T_DP + C;
    localparam int LAT  = T_Q + 1;

    typedef struct packed {
        logic signed [E-1:0] dx;
        logic signed [E-1:0] dy;
        logic [R2-1:0]       d;
        logic [OW-1:0]       ofs;
        logic                dzero;
    } t_side1;

    typedef struct packed {
        logic [R2-1:0] d;
        logic [OW-1:0] ofs;
        logic          dzero;
    } t_side2;

    typedef struct packed {
        logic [7:0] sat;
        logic       dzero;
        logic       kneg;
    } t_flags;

    logic accept;
    logic [LAT-1:0] r_vld;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid pipeline, one bit per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Stage 1: differences and sums of coordinates.
    logic signed [E-1:0] r1_eax, r1_eay, r1_ebx, r1_eby, r1_dx, r1_dy, r1_sx, r1_sy;

    always_ff @(posedge i_clk) begin
        r1_eax <= E'(i_req.first_map_x) - E'(i_req.first_seen_x);
        r1_eay <= E'(i_req.first_map_y) - E'(i_req.first_seen_y);
        r1_ebx <= E'(i_req.second_map_x) - E'(i_req.second_seen_x);
        r1_eby <= E'(i_req.second_map_y) - E'(i_req.second_seen_y);
        r1_dx  <= E'(i_req.second_map_x) - E'(i_req.first_map_x);
        r1_dy  <= E'(i_req.second_map_y) - E'(i_req.first_map_y);
        r1_sx  <= E'(i_req.first_map_x) + E'(i_req.second_map_x);
        r1_sy  <= E'(i_req.first_map_y) + E'(i_req.second_map_y);
    end

    // Stage 2: six narrow squares.
    logic signed [2*E-1:0] r2_qax, r2_qay, r2_qbx, r2_qby, r2_qdx, r2_qdy;
    logic signed [E-1:0]   r2_dx, r2_dy, r2_sx, r2_sy;

    always_ff @(posedge i_clk) begin
        r2_qax <= r1_eax * r1_eax;
        r2_qay <= r1_eay * r1_eay;
        r2_qbx <= r1_ebx * r1_ebx;
        r2_qby <= r1_eby * r1_eby;
        r2_qdx <= r1_dx * r1_dx;
        r2_qdy <= r1_dy * r1_dy;
        r2_dx  <= r1_dx;
        r2_dy  <= r1_dy;
        r2_sx  <= r1_sx;
        r2_sy  <= r1_sy;
    end

    // Stage 3: squared radii and squared center distance.
    logic [R2-1:0]       r3_ra2, r3_rb2, r3_d;
    logic signed [E-1:0] r3_dx, r3_dy, r3_sx, r3_sy;

    always_ff @(posedge i_clk) begin
        r3_ra2 <= $unsigned(r2_qax) + $unsigned(r2_qay);
        r3_rb2 <= $unsigned(r2_qbx) + $unsigned(r2_qby);
        r3_d   <= $unsigned(r2_qdx) + $unsigned(r2_qdy);
        r3_dx  <= r2_dx;
        r3_dy  <= r2_dy;
        r3_sx  <= r2_sx;
        r3_sy  <= r2_sy;
    end

    // Stage 4: difference and doubled sum of squared radii.
    logic signed [R2:0]  r4_a;
    logic [R2+1:0]       r4_s2;
    logic [R2-1:0]       r4_d;
    logic                r4_dzero;
    logic signed [E-1:0] r4_dx, r4_dy, r4_sx, r4_sy;

    always_ff @(posedge i_clk) begin
        r4_a     <= $signed({1'b0, r3_ra2}) - $signed({1'b0, r3_rb2});
        r4_s2    <= {(R2+1)'(r3_ra2) + (R2+1)'(r3_rb2), 1'b0};
        r4_d     <= r3_d;
        r4_dzero <= (r3_d == '0);
        r4_dx    <= r3_dx;
        r4_dy    <= r3_dy;
        r4_sx    <= r3_sx;
        r4_sy    <= r3_sy;
    end

    // Discriminant terms: 2S*D, A*A and D*D.
    logic signed [AK-1:0] k_s2, k_a, k_d;
    logic signed [KW-1:0] p_sd, p_aa, p_dd;

    assign k_s2 = AK'($signed({1'b0, r4_s2}));
    assign k_a  = AK'(r4_a);
    assign k_d  = AK'($signed({1'b0, r4_d}));

    tci_mul #(.AW(AK), .BW(AK)) u_mul_sd (.i_clk(i_clk), .i_a(k_s2), .i_b(k_d), .o_p(p_sd));
    tci_mul #(.AW(AK), .BW(AK)) u_mul_aa (.i_clk(i_clk), .i_a(k_a), .i_b(k_a), .o_p(p_aa));
    tci_mul #(.AW(AK), .BW(AK)) u_mul_dd (.i_clk(i_clk), .i_a(k_d), .i_b(k_d), .o_p(p_dd));

    // Discriminant and its sign.
    logic signed [KW-1:0] r_k;
    logic                 r_kneg;

    always_ff @(posedge i_clk) begin
        r_k    <= p_sd - p_aa - p_dd;
        r_kneg <= (p_sd - p_aa - p_dd) < 0;
    end

    // Integer square root of the discriminant.
    logic [RB-1:0] w_root;

    tci_sqrt #(.RB(RB)) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_k[2*RB-1:0]),
        .o_root (w_root)
    );

    // Base numerator terms: (ax+bx)*D + A*dx and the same for y.
    logic signed [R2:0]    nd;
    logic signed [PNW-1:0] p_sxd, p_adx, p_syd, p_ady;
    logic signed [BSW-1:0] r_bxs, r_bys, w_bxs_d, w_bys_d;

    assign nd = $signed({1'b0, r4_d});

    tci_mul #(.AW(R2+1), .BW(E)) u_mul_sxd (.i_clk(i_clk), .i_a(nd), .i_b(r4_sx), .o_p(p_sxd));
    tci_mul #(.AW(R2+1), .BW(E)) u_mul_adx (.i_clk(i_clk), .i_a(r4_a), .i_b(r4_dx), .o_p(p_adx));
    tci_mul #(.AW(R2+1), .BW(E)) u_mul_syd (.i_clk(i_clk), .i_a(nd), .i_b(r4_sy), .o_p(p_syd));
    tci_mul #(.AW(R2+1), .BW(E)) u_mul_ady (.i_clk(i_clk), .i_a(r4_a), .i_b(r4_dy), .o_p(p_ady));

    always_ff @(posedge i_clk) begin
        r_bxs <= BSW'(p_sxd) + BSW'(p_adx);
        r_bys <= BSW'(p_syd) + BSW'(p_ady);
    end

    tci_delay #(.W(BSW), .N(LK + RB)) u_dly_bxs (.i_clk(i_clk), .i_d(r_bxs), .o_q(w_bxs_d));
    tci_delay #(.W(BSW), .N(LK + RB)) u_dly_bys (.i_clk(i_clk), .i_d(r_bys), .o_q(w_bys_d));

    // Side data waits for the root; the offset folds rounding and the quotient bias.
    t_side1 side1_in, side1_rt;
    t_side2 side2_in, side2_tx;
    logic   w_kneg_tx;

    assign side1_in.dx    = r4_dx;
    assign side1_in.dy    = r4_dy;
    assign side1_in.d     = r4_d;
    assign side1_in.ofs   = OW'(r4_d) + (OW'(r4_d) << C);
    assign side1_in.dzero = r4_dzero;

    tci_delay #(.W($bits(t_side1)), .N(LK + 1 + RB)) u_dly_side1 (
        .i_clk (i_clk),
        .i_d   (side1_in),
        .o_q   (side1_rt)
    );

    assign side2_in.d     = side1_rt.d;
    assign side2_in.ofs   = side1_rt.ofs;
    assign side2_in.dzero = side1_rt.dzero;

    tci_delay #(.W($bits(t_side2)), .N(LN)) u_dly_side2 (
        .i_clk (i_clk),
        .i_d   (side2_in),
        .o_q   (side2_tx)
    );

    tci_delay #(.W(1), .N(RB + LN)) u_dly_kneg (.i_clk(i_clk), .i_d(r_kneg), .o_q(w_kneg_tx));

    // Root terms: root*dy and root*dx.
    logic signed [RB:0]    root_s;
    logic signed [TXW-1:0] p_rdy, p_rdx;

    assign root_s = $signed({1'b0, w_root});

    tci_mul #(.AW(RB+1), .BW(E)) u_mul_rdy (
        .i_clk(i_clk), .i_a(root_s), .i_b(side1_rt.dy), .o_p(p_rdy)
    );
    tci_mul #(.AW(RB+1), .BW(E)) u_mul_rdx (
        .i_clk(i_clk), .i_a(root_s), .i_b(side1_rt.dx), .o_p(p_rdx)
    );

    // Biased, rounded numerators of all four coordinates.
    logic signed [NW-1:0] r_nx1, r_ny1, r_nx2, r_ny2;
    logic [TW-1:0]        r_nt;
    logic                 r_ndz, r_nkn;
    logic signed [NW-1:0] ofs_s;

    assign ofs_s = $signed(NW'(side2_tx.ofs));

    always_ff @(posedge i_clk) begin
        r_nx1 <= NW'(w_bxs_d) + NW'(p_rdy) + ofs_s;
        r_nx2 <= NW'(w_bxs_d) - NW'(p_rdy) + ofs_s;
        r_ny1 <= NW'(w_bys_d) - NW'(p_rdx) + ofs_s;
        r_ny2 <= NW'(w_bys_d) + NW'(p_rdx) + ofs_s;
        r_nt  <= {side2_tx.d, 1'b0};
        r_ndz <= side2_tx.dzero;
        r_nkn <= w_kneg_tx;
    end

    // Saturation checks against the biased quotient range.
    logic signed [NW-1:0] lim;
    logic [DV-1:0]        r_dx1, r_dy1, r_dx2, r_dy2;
    logic [TW-1:0]        r_pt;
    t_flags               r_pf, w_qf;

    assign lim = $signed(NW'(r_nt) << C);

    always_ff @(posedge i_clk) begin
        r_dx1 <= r_nx1[DV-1:0];
        r_dy1 <= r_ny1[DV-1:0];
        r_dx2 <= r_nx2[DV-1:0];
        r_dy2 <= r_ny2[DV-1:0];
        r_pt  <= r_nt;
        r_pf.sat <= {r_nx1 >= lim, r_nx1[NW-1], r_ny1 >= lim, r_ny1[NW-1],
                     r_nx2 >= lim, r_nx2[NW-1], r_ny2 >= lim, r_ny2[NW-1]};
        r_pf.dzero <= r_ndz;
        r_pf.kneg  <= r_nkn;
    end

    // Four dividers by 2D.
    logic [C-1:0] q_x1, q_y1, q_x2, q_y2;

    tci_div #(.DW(TW), .QW(C)) u_div_x1 (.i_clk(i_clk), .i_num(r_dx1), .i_den(r_pt), .o_quo(q_x1));
    tci_div #(.DW(TW), .QW(C)) u_div_y1 (.i_clk(i_clk), .i_num(r_dy1), .i_den(r_pt), .o_quo(q_y1));
    tci_div #(.DW(TW), .QW(C)) u_div_x2 (.i_clk(i_clk), .i_num(r_dx2), .i_den(r_pt), .o_quo(q_x2));
    tci_div #(.DW(TW), .QW(C)) u_div_y2 (.i_clk(i_clk), .i_num(r_dy2), .i_den(r_pt), .o_quo(q_y2));

    tci_delay #(.W($bits(t_flags)), .N(C)) u_dly_flags (.i_clk(i_clk), .i_d(r_pf), .o_q(w_qf));

    // Remove the quotient bias, or clamp when out of range.
    function automatic t_coord fix_coord(input logic [C-1:0] q, input logic hi,
                                         input logic lo);
        t_coord v;
        v = $signed({~q[C-1], q[C-2:0]});
        if (hi) begin
            v = $signed({1'b0, {(C-1){1'b1}}});
        end else if (lo) begin
            v = $signed({1'b1, {(C-1){1'b0}}});
        end
        return v;
    endfunction

    // Output register.
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (w_qf.dzero) begin
            r_res <= '{default: '0, status: ST_SAME};
        end else if (w_qf.kneg) begin
            r_res <= '{default: '0, status: ST_APART};
        end else begin
            r_res.point_one_x <= fix_coord(q_x1, w_qf.sat[7], w_qf.sat[6]);
            r_res.point_one_y <= fix_coord(q_y1, w_qf.sat[5], w_qf.sat[4]);
            r_res.point_two_x <= fix_coord(q_x2, w_qf.sat[3], w_qf.sat[2]);
            r_res.point_two_y <= fix_coord(q_y2, w_qf.sat[1], w_qf.sat[0]);
            r_res.status      <= ST_OK;
        end
    end

    assign o_res   = r_res;
    assign o_valid = r_vld[LAT-1];

    // All four point fields of the result are zero.
    logic pts_zero;

    assign pts_zero = (o_res.point_one_x == '0) && (o_res.point_one_y == '0) &&
                      (o_res.point_two_x == '0) && (o_res.point_two_y == '0);

    // An error result carries zero points.
    `TCI_ASSERT_IMP(a_err_zero, o_valid && o_res.status != ST_OK, pts_zero)
    // Only defined status codes leave the block.
    `TCI_ASSERT_IMP(a_status_ok, o_valid, o_res.status == ST_OK || o_res.status == ST_SAME || o_res.status == ST_APART)
    // An accepted request enters the first stage on the next cycle.
    `TCI_ASSERT_NXT(a_accept_enters, accept, r_vld[0])

endmodule

// ----- verif/two_circle_intersection_top_test.sv -----
module two_circle_intersection_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tci_pkg::*;

    typedef logic signed [159:0] t_wide;

    // Fix solver and the queue of fixes still owed by the block.
    class t_fix_scoreboard;
        t_res owed_fixes[$];
        int   fault_cnt;

        function new();
            fault_cnt = 0;
        endfunction

        // floor(n / (2d)) after adding d, then clamp to the coordinate range.
        function t_coord round_clamp(t_wide n, t_wide d);
            t_wide num;
            t_wide den;
            t_wide q;
            num = n + d;
            den = d + d;
            q = num / den;
            if (num < 0 && (num % den) != 0) begin
                q = q - 1;
            end
            if (q > 8388607) begin
                q = 8388607;
            end
            if (q < -8388608) begin
                q = -8388608;
            end
            return t_coord'(q[COORD_W-1:0]);
        endfunction

        function t_res solve_fix(t_req r);
            t_wide ax, ay, bx, by, ra2, rb2, dx, dy, d, a_t, s_t, k, root, trial;
            t_wide sx, sy, tx, ty;
            t_res  fix;
            ax = $signed(r.first_map_x);
            ay = $signed(r.first_map_y);
            bx = $signed(r.second_map_x);
            by = $signed(r.second_map_y);
            ra2 = (ax - $signed(r.first_seen_x)) * (ax - $signed(r.first_seen_x))
                + (ay - $signed(r.first_seen_y)) * (ay - $signed(r.first_seen_y));
            rb2 = (bx - $signed(r.second_seen_x)) * (bx - $signed(r.second_seen_x))
                + (by - $signed(r.second_seen_y)) * (by - $signed(r.second_seen_y));
            dx = bx - ax;
            dy = by - ay;
            d = dx * dx + dy * dy;
            fix = '0;
            if (d == 0) begin
                fix.status = ST_SAME;
                return fix;
            end
            a_t = ra2 - rb2;
            s_t = ra2 + rb2;
            k = 2 * s_t * d - a_t * a_t - d * d;
            if (k < 0) begin
                fix.status = ST_APART;
                return fix;
            end
            // Integer square root, one bit at a time.
            root = 0;
            for (int b = 70; b >= 0; b--) begin
                trial = root | (t_wide'(1) <<< b);
                if (trial * trial <= k) begin
                    root = trial;
                end
            end
            sx = (ax + bx) * d + a_t * dx;
            sy = (ay + by) * d + a_t * dy;
            tx = root * dy;
            ty = -(root * dx);
            fix.point_one_x = round_clamp(sx + tx, d);
            fix.point_one_y = round_clamp(sy + ty, d);
            fix.point_two_x = round_clamp(sx - tx, d);
            fix.point_two_y = round_clamp(sy - ty, d);
            fix.status = ST_OK;
            return fix;
        endfunction

        function void note_request(t_req r);
            owed_fixes.push_back(solve_fix(r));
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                fault_cnt++;
            end
        endfunction

        function void check_fix(t_res got);
            t_res want;
            if (owed_fixes.size() == 0) begin
                $display("%0t: unexpected result %0h", $time, got);
                fault_cnt++;
                return;
            end
            want = owed_fixes.pop_front();
            compare_field("point_one_x", 32'(want.point_one_x), 32'(got.point_one_x));
            compare_field("point_one_y", 32'(want.point_one_y), 32'(got.point_one_y));
            compare_field("point_two_x", 32'(want.point_two_x), 32'(got.point_two_x));
            compare_field("point_two_y", 32'(want.point_two_y), 32'(got.point_two_y));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_res o_res;

    t_fix_scoreboard fixes;
    int idle_cycles = 0;

    two_circle_intersection_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Record accepted requests and check results; count idle cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (start && !busy) begin
                fixes.note_request(i_req);
            end
            if (o_valid) begin
                fixes.check_fix(o_res);
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if (idle_cycles > 3000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 150);
    endfunction

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    // Signed value with magnitude below 2^bits.
    function automatic int near_val(int bits);
        int v;
        v = int'($urandom_range(0, (1 << bits) - 1));
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    // Observations built so both circles pass through one common point.
    function automatic t_req meeting_pair(int bits);
        t_req r;
        int ax, ay, bx, by, px, py;
        ax = near_val(bits);
        ay = near_val(bits);
        bx = ax + near_val(bits);
        by = ay + near_val(bits);
        px = ax + near_val(bits);
        py = ay + near_val(bits);
        r.first_map_x = t_coord'(ax);
        r.first_map_y = t_coord'(ay);
        r.second_map_x = t_coord'(bx);
        r.second_map_y = t_coord'(by);
        // A quarter turn of the radius vector keeps its length.
        if ($urandom_range(0, 1) != 0) begin
            r.first_seen_x = t_coord'(ax + (py - ay));
            r.first_seen_y = t_coord'(ay - (px - ax));
        end else begin
            r.first_seen_x = t_coord'(px);
            r.first_seen_y = t_coord'(py);
        end
        if ($urandom_range(0, 1) != 0) begin
            r.second_seen_x = t_coord'(bx - (py - by));
            r.second_seen_y = t_coord'(by + (px - bx));
        end else begin
            r.second_seen_x = t_coord'(px);
            r.second_seen_y = t_coord'(py);
        end
        return r;
    endfunction

    // Offer one request and hold it until taken; drop start only for a gap.
    task automatic send_request(t_req r, int gap);
        i_req <= r;
        start <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_all();
        start <= 1'b0;
        @(posedge i_clk);
        while (fixes.owed_fixes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_req r;
        t_req list[$];
        int roll;
        fixes = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: coincident centers, extremes, tangent and apart circles.
        r = '0;
        list.push_back(r);
        r = '{default: t_coord'(24'h7fffff)};
        list.push_back(r);
        r = '{default: t_coord'(24'h800000)};
        list.push_back(r);
        r = '0;
        r.second_map_x = 24'sd2;
        r.first_seen_x = 24'sd1;
        r.second_seen_x = 24'sd1;
        list.push_back(r);
        r = '0;
        r.second_map_x = 24'sd100;
        r.first_seen_x = 24'sd1;
        r.second_seen_x = 24'sd99;
        list.push_back(r);
        r = '0;
        r.first_map_x = 24'h800000;
        r.first_map_y = 24'h800000;
        r.second_map_x = 24'h7fffff;
        r.second_map_y = 24'h7fffff;
        r.first_seen_x = 24'h7fffff;
        r.first_seen_y = 24'h800000;
        r.second_seen_x = 24'h800000;
        r.second_seen_y = 24'h7fffff;
        list.push_back(r);
        r.first_seen_x = 24'h800000;
        r.first_seen_y = 24'h7fffff;
        list.push_back(r);
        r = '0;
        r.first_map_x = 24'h7fffff;
        r.second_map_x = 24'h7ffffe;
        r.first_seen_x = 24'h800000;
        r.second_seen_y = 24'h7fffff;
        list.push_back(r);
        for (int i = 0; i < 8; i++) begin
            list.push_back(meeting_pair(4 + 2 * i));
        end
        for (int i = 0; i < 4; i++) begin
            list.push_back('{any_coord(), any_coord(), any_coord(), any_coord(),
                             any_coord(), any_coord(), any_coord(), any_coord()});
        end
        foreach (list[i]) begin
            send_request(list[i], pick_gap());
        end

        // Let everything drain once before the random traffic.
        drain_all();

        for (int i = 0; i < 450; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                r = meeting_pair($urandom_range(0, 3) == 0 ? 22 : $urandom_range(1, 16));
            end else if (roll < 80) begin
                r = meeting_pair($urandom_range(1, 12));
                r.second_map_x = r.first_map_x;
                r.second_map_y = r.first_map_y;
            end else begin
                r = '{any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord()};
            end
            // Long bursts without any gap.
            send_request(r, (i % 100 < 30) ? 0 : pick_gap());
        end

        drain_all();
        repeat (150) @(posedge i_clk);
        if (fixes.fault_cnt == 0 && fixes.owed_fixes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
